// File: rtl/bpa_pkg.sv
package bpa_pkg;

   localparam int MaxPages = 4096;
   localparam int PageW = 13;
   localparam int WordW = 64;
   localparam int NumWords = MaxPages / WordW + 1;
   localparam int AddrW = $clog2(NumWords);
   localparam int BitW = $clog2(WordW);

   typedef enum logic [3:0] {
      ACT_RESERVE   = 4'd0,
      ACT_RELEASE   = 4'd1,
      ACT_NEXT_PAGE = 4'd2,
      ACT_NEXT_CUR  = 4'd3,
      ACT_PREV      = 4'd4,
      ACT_FIRST     = 4'd5,
      ACT_LAST      = 4'd6,
      ACT_GET       = 4'd7,
      ACT_RST_CUR   = 4'd8,
      ACT_QUERY     = 4'd9
   } action_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_INVALID = 3'd1,
      ST_EOF     = 3'd2,
      ST_LIMIT   = 3'd3,
      ST_PINNED  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_SCAN,
      S_WRITE,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      SCAN_NONE,
      SCAN_FREE,
      SCAN_UP,
      SCAN_DOWN
   } scan_type;

   typedef struct packed {
      logic load;
      logic clear_step;
      logic read;
      logic scan_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic     clear_done;
      scan_type kind;
      logic     scan_done;
   } stat_type;

endpackage

// File: rtl/bpa_ctrl.sv
module bpa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   input  logic              rsp_fire,
   input  bpa_pkg::stat_type stat,
   output bpa_pkg::cmd_type  cmd,
   output logic              req_tready,
   output logic              rsp_tvalid
);

   bpa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpa_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bpa_pkg::S_CLEAR: if (stat.clear_done) state_in = bpa_pkg::S_IDLE;
         bpa_pkg::S_IDLE: if (req_fire) state_in = bpa_pkg::S_READ;
         bpa_pkg::S_READ: begin
            if (stat.kind == bpa_pkg::SCAN_NONE) begin
               state_in = bpa_pkg::S_WRITE;
            end else begin
               state_in = bpa_pkg::S_SCAN;
            end
         end
         bpa_pkg::S_SCAN: if (stat.scan_done) state_in = bpa_pkg::S_WRITE;
         bpa_pkg::S_WRITE: state_in = bpa_pkg::S_DONE;
         bpa_pkg::S_DONE: if (rsp_fire) state_in = bpa_pkg::S_IDLE;
         default: state_in = bpa_pkg::S_CLEAR;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         bpa_pkg::S_CLEAR: cmd.clear_step = 1'b1;
         bpa_pkg::S_IDLE: begin
            req_tready = 1'b1;
            cmd.load = req_fire;
         end
         bpa_pkg::S_READ: cmd.read = 1'b1;
         bpa_pkg::S_SCAN: cmd.scan_step = 1'b1;
         bpa_pkg::S_WRITE: cmd.commit = 1'b1;
         bpa_pkg::S_DONE: rsp_tvalid = 1'b1;
         default: cmd = '0;
      endcase
   end

`ifndef SYNTH
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != bpa_pkg::S_IDLE |-> !req_tready) else $error("busy accept");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_fire |=> rsp_tvalid) else $error("rsp dropped");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> state_ff == bpa_pkg::S_IDLE) else $error("load outside idle");
`endif

endmodule

// File: rtl/bpa_dp.sv
module bpa_dp (
   input  logic              clock,
   input  logic              reset,
   input  bpa_pkg::cmd_type  cmd,
   output bpa_pkg::stat_type stat,
   input  logic [3:0]        in_action,
   input  logic [12:0]       in_page,
   input  logic              in_pinned,
   output logic [2:0]        out_status,
   output logic [12:0]       out_page,
   output logic [12:0]       out_alloc,
   output logic [12:0]       out_resv
);

   localparam int AW = bpa_pkg::AddrW;
   localparam int BW = bpa_pkg::BitW;
   localparam int WW = bpa_pkg::WordW;
   localparam int PW = bpa_pkg::PageW;
   localparam logic [AW-1:0] LastWord = AW'(bpa_pkg::NumWords - 1);

   logic [WW-1:0] mem [bpa_pkg::NumWords];
   logic [WW-1:0] rdata_ff;

   logic [3:0]    act_ff;
   logic [PW-1:0] page_ff;
   logic          pin_ff;
   logic [PW-1:0] alloc_ff, alloc_in;
   logic [PW-1:0] resv_ff, resv_in;
   logic [PW-1:0] cur_ff, cur_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [AW-1:0] clr_ff;
   logic          clr_done_ff;
   logic [2:0]    st_ff, st_in;
   logic [PW-1:0] res_ff, res_in;
   logic [PW-1:0] lo_ff, hi_ff;
   logic [PW-1:0] found_ff;
   logic          hit_ff;
   logic [WW-1:0] wdata_ff;
   logic          we_ff;
   logic          first_ff;
   bpa_pkg::scan_type kind_ff, kind_in;
   logic [PW-1:0] lo_in, hi_in;

   // scan bounds from the loaded item
   logic [PW:0] up_start;
   always_comb begin
      kind_in = bpa_pkg::SCAN_NONE;
      lo_in = '0;
      hi_in = alloc_ff;
      up_start = '0;
      case (act_ff)
         bpa_pkg::ACT_RESERVE: begin
            kind_in = bpa_pkg::SCAN_FREE;
            lo_in = PW'(1);
            hi_in = PW'(bpa_pkg::MaxPages);
         end
         bpa_pkg::ACT_NEXT_PAGE, bpa_pkg::ACT_NEXT_CUR, bpa_pkg::ACT_FIRST: begin
            kind_in = bpa_pkg::SCAN_UP;
            if (act_ff == bpa_pkg::ACT_NEXT_PAGE) up_start = {1'b0, page_ff} + 1'b1;
            else if (act_ff == bpa_pkg::ACT_NEXT_CUR) up_start = {1'b0, cur_ff} + 1'b1;
            else up_start = (PW+1)'(1);
            lo_in = up_start[PW] ? {PW{1'b1}} : up_start[PW-1:0];
            if (lo_in == '0) lo_in = PW'(1);
         end
         bpa_pkg::ACT_PREV: begin
            kind_in = bpa_pkg::SCAN_DOWN;
            lo_in = PW'(1);
            hi_in = (page_ff == '0) ? '0
                  : ((page_ff - 1'b1) > alloc_ff ? alloc_ff : page_ff - 1'b1);
         end
         bpa_pkg::ACT_LAST: kind_in = bpa_pkg::SCAN_DOWN;
         default: kind_in = bpa_pkg::SCAN_NONE;
      endcase
      if (act_ff == bpa_pkg::ACT_LAST) lo_in = PW'(1);
   end

   // per-word masked search
   logic [PW-1:0] wbase;
   logic [WW-1:0] cand;
   logic          any;
   logic [BW-1:0] lo_idx, hi_idx;
   always_comb begin
      wbase = PW'(addr_ff) << BW;
      for (int i = 0; i < WW; i++) begin
         cand[i] = ((kind_ff == bpa_pkg::SCAN_FREE) ? !rdata_ff[i] : rdata_ff[i])
                 && ((wbase + PW'(i)) >= lo_ff) && ((wbase + PW'(i)) <= hi_ff);
      end
      any = |cand;
      lo_idx = '0;
      for (int i = WW - 1; i >= 0; i--) if (cand[i]) lo_idx = BW'(i);
      hi_idx = '0;
      for (int i = 0; i < WW; i++) if (cand[i]) hi_idx = BW'(i);
   end

   logic [AW-1:0] lo_w, hi_w;
   assign lo_w = AW'(lo_ff >> BW);
   assign hi_w = AW'(hi_ff >> BW);

   logic scan_end;
   always_comb begin
      if (kind_ff == bpa_pkg::SCAN_DOWN) scan_end = any || addr_ff == '0 || addr_ff <= lo_w;
      else scan_end = any || addr_ff >= hi_w || addr_ff == LastWord;
      if (lo_ff > hi_ff) scan_end = 1'b1;
   end

   assign stat.clear_done = clr_done_ff;
   assign stat.kind = kind_in;
   assign stat.scan_done = cmd.scan_step && !first_ff && scan_end;

   logic [AW-1:0] page_w;
   logic [BW-1:0] page_b;
   assign page_w = AW'(page_ff >> BW);
   assign page_b = page_ff[BW-1:0];

   logic [AW-1:0] hi_w_in;
   assign hi_w_in = AW'(hi_in >> BW);

   always_comb begin
      addr_in = addr_ff;
      if (cmd.read) begin
         if (kind_in == bpa_pkg::SCAN_DOWN) addr_in = hi_w_in;
         else if (kind_in == bpa_pkg::SCAN_NONE) addr_in = page_w;
         else addr_in = AW'(lo_in >> BW);
      end else if (cmd.scan_step && !first_ff && !scan_end) begin
         addr_in = (kind_ff == bpa_pkg::SCAN_DOWN) ? addr_ff - 1'b1 : addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step) mem[clr_ff] <= '0;
      else if (we_ff) mem[addr_ff] <= wdata_ff;
      rdata_ff <= mem[addr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         clr_done_ff <= 1'b0;
         alloc_ff <= '0;
         resv_ff <= '0;
         cur_ff <= '0;
         kind_ff <= bpa_pkg::SCAN_NONE;
         first_ff <= 1'b0;
         we_ff <= 1'b0;
         hit_ff <= 1'b0;
         addr_ff <= '0;
      end else begin
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + 1'b1;
            clr_done_ff <= (clr_ff == LastWord - 1'b1);
         end
         alloc_ff <= alloc_in;
         resv_ff <= resv_in;
         cur_ff <= cur_in;
         addr_ff <= addr_in;
         we_ff <= 1'b0;
         if (cmd.read) begin
            kind_ff <= kind_in;
            first_ff <= 1'b1;
            hit_ff <= 1'b0;
         end
         if (cmd.scan_step) begin
            first_ff <= 1'b0;
            if (!first_ff && any) begin
               hit_ff <= 1'b1;
               found_ff <= wbase + PW'((kind_ff == bpa_pkg::SCAN_DOWN) ? hi_idx : lo_idx);
            end
         end
         if (cmd.commit) begin
            kind_ff <= bpa_pkg::SCAN_NONE;
            if (act_ff == bpa_pkg::ACT_RESERVE && hit_ff) begin
               wdata_ff <= rdata_ff | (WW'(1) << found_ff[BW-1:0]);
               we_ff <= 1'b1;
            end else if (act_ff == bpa_pkg::ACT_RELEASE && st_in == bpa_pkg::ST_OK) begin
               wdata_ff <= rdata_ff & ~(WW'(1) << page_b);
               we_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= in_action;
         page_ff <= in_page;
         pin_ff <= in_pinned;
      end
      if (cmd.read) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
      if (cmd.commit) begin
         st_ff <= st_in;
         res_ff <= res_in;
      end
   end

   logic bit_set, pvalid, in_range;
   assign in_range = page_ff != '0 && page_ff <= PW'(bpa_pkg::MaxPages);
   assign bit_set = in_range && rdata_ff[page_b];
   assign pvalid = bit_set && page_ff <= alloc_ff;

   always_comb begin
      st_in = bpa_pkg::ST_OK;
      res_in = '0;
      alloc_in = alloc_ff;
      resv_in = resv_ff;
      cur_in = cur_ff;
      if (cmd.commit) begin
         case (act_ff)
            bpa_pkg::ACT_RESERVE: begin
               if (!hit_ff) st_in = bpa_pkg::ST_LIMIT;
               else begin
                  res_in = found_ff;
                  resv_in = resv_ff + 1'b1;
                  if (found_ff > alloc_ff) alloc_in = found_ff;
               end
            end
            bpa_pkg::ACT_RELEASE: begin
               if (!pvalid) st_in = bpa_pkg::ST_INVALID;
               else if (pin_ff) st_in = bpa_pkg::ST_PINNED;
               else resv_in = resv_ff - 1'b1;
            end
            bpa_pkg::ACT_NEXT_PAGE, bpa_pkg::ACT_NEXT_CUR, bpa_pkg::ACT_PREV,
            bpa_pkg::ACT_FIRST, bpa_pkg::ACT_LAST: begin
               if (!hit_ff) st_in = bpa_pkg::ST_EOF;
               else begin
                  res_in = found_ff;
                  cur_in = found_ff;
               end
            end
            bpa_pkg::ACT_GET: begin
               if (!pvalid) st_in = bpa_pkg::ST_INVALID;
               else begin
                  res_in = page_ff;
                  cur_in = page_ff;
               end
            end
            bpa_pkg::ACT_RST_CUR: cur_in = '0;
            bpa_pkg::ACT_QUERY: res_in = PW'(bit_set);
            default: st_in = bpa_pkg::ST_INVALID;
         endcase
      end
   end

   assign out_status = st_ff;
   assign out_page = res_ff;
   assign out_alloc = alloc_ff;
   assign out_resv = resv_ff;

`ifndef SYNTH
   a_resv_le_alloc: assert property (@(posedge clock) disable iff (reset)
      resv_ff <= alloc_ff) else $error("reserved exceeds allocated");
   a_alloc_mono: assert property (@(posedge clock) disable iff (reset)
      alloc_ff >= $past(alloc_ff)) else $error("allocated fell");
   a_no_write_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_step |-> !we_ff) else $error("write during clear");
`endif

endmodule

// File: rtl/bitmap_page_allocator_core.sv
// channel | direction | fields (low bit first)
// req     | in        | tdata: action[3:0], page_id[16:4], page_pinned[17]
// rsp     | out       | tdata: status[2:0], result_page[15:3],
//         |           |        allocated_count[28:16], reserved_count[41:29]
// a transaction without a scan passes through the read, write and done states; a scan
// adds a scan state that visits the bitmap words one after another (64 pages a word,
// 65 words), as the single word memory port reads one word at a time
// after reset a clearing pass zeroes all 65 bitmap words before req_tready rises
// one transaction at a time; rsp_tvalid holds until the result is taken
module bitmap_page_allocator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // action, page_id, page_pinned
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // status, result_page, allocated_count, reserved_count
);

   bpa_pkg::cmd_type  cmd;
   bpa_pkg::stat_type stat;
   logic [2:0]  st;
   logic [12:0] pg, al, rs;

   bpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_fire   (req_tvalid && req_tready),
      .rsp_fire   (rsp_tvalid && rsp_tready),
      .stat       (stat),
      .cmd        (cmd),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid)
   );

   bpa_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .in_action  (req_tdata[3:0]),
      .in_page    (req_tdata[16:4]),
      .in_pinned  (req_tdata[17]),
      .out_status (st),
      .out_page   (pg),
      .out_alloc  (al),
      .out_resv   (rs)
   );

   assign rsp_tdata = {6'd0, rs, al, pg, st};

endmodule
